[hdl/dhlt_pkg.sv]
// ----------------------------------------------------------------------------
// dhlt_pkg
// Shared constants for the link transform: the cordic angle table, the fixed
// point constants of the q2.30 datapath and a bus width helper.
// ----------------------------------------------------------------------------
package dhlt_pkg;

  localparam int INT_FRAC = 30;
  localparam int X_W      = 32;
  localparam int Z_W      = 33;
  localparam int Z_IN_W   = 34;

  localparam logic signed [X_W-1:0]    GAIN_Q30    = 32'sd652032874;
  localparam logic signed [Z_IN_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_IN_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // atan(2^-i) in q30, truncated
  localparam int ATAN_Q30 [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1, 0, 0
  };

  // bit width rounded up to whole bytes
  function automatic int byte_bits(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

[hdl/dh_link_transform.sv]
// ----------------------------------------------------------------------------
// dh_link_transform
// Denavit-Hartenberg link transform: rotation and translation of one link
// from its joint angle, twist angle, length and offset.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while in_tready is high, set by the cordic
// with one iteration per stage
// in_tready drops only while the output register and its skid entry both hold
// a result
// reset: synchronous rst_n clears all valid flags, data registers keep contents
// ----------------------------------------------------------------------------
module dh_link_transform import dhlt_pkg::*; #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int COEFF_WIDTH   = 16,
  parameter int LENGTH_WIDTH  = 32,
  parameter int CORDIC_STAGES = 16,
  localparam int IN_DW  = byte_bits(2 * ANGLE_WIDTH + 2 * LENGTH_WIDTH),
  localparam int OUT_DW = byte_bits(8 * COEFF_WIDTH + 1 + 3 * LENGTH_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // joint_angle, twist_angle, link_len, link_offset
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // trans_x, trans_y, trans_z
  output logic [OUT_DW-1:0] out_tdata
);

  localparam int AW  = ANGLE_WIDTH;
  localparam int LW  = LENGTH_WIDTH;
  localparam int CL  = CORDIC_STAGES + 2;
  localparam int VL  = CORDIC_STAGES + 4;

  logic                  en;
  logic                  push;
  logic [VL-1:0]         vld_r;
  logic [2*LW-1:0]       ld_r [CL];

  logic signed [AW-1:0]  joint_angle, twist_angle;
  logic signed [COEFF_WIDTH-1:0] cj, sj, ct, st;
  logic signed [LW-1:0]  len_d, off_d;

  logic signed [COEFF_WIDTH-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
  logic signed [COEFF_WIDTH-1:0] rot_21, rot_22;
  logic signed [LW-1:0]  trans_x, trans_y, trans_z;
  logic [OUT_DW-1:0]     res_data;

  assign in_tready   = en;
  assign joint_angle = in_tdata[AW-1:0];
  assign twist_angle = in_tdata[2*AW-1:AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VL-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r[0] <= in_tdata[2*AW+2*LW-1:2*AW];
      for (int k = 1; k < CL; k++) begin
        ld_r[k] <= ld_r[k-1];
      end
    end
  end

  assign len_d = ld_r[CL-1][LW-1:0];
  assign off_d = ld_r[CL-1][2*LW-1:LW];

  dhlt_cordic #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .COEFF_WIDTH   (COEFF_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic_joint (
    .clk   (clk),
    .en    (en),
    .angle (joint_angle),
    .cos_o (cj),
    .sin_o (sj)
  );

  dhlt_cordic #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .COEFF_WIDTH   (COEFF_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic_twist (
    .clk   (clk),
    .en    (en),
    .angle (twist_angle),
    .cos_o (ct),
    .sin_o (st)
  );

  dhlt_product #(
    .COEFF_WIDTH  (COEFF_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_product (
    .clk         (clk),
    .en          (en),
    .cj          (cj),
    .sj          (sj),
    .ct          (ct),
    .st          (st),
    .link_len    (len_d),
    .link_offset (off_d),
    .rot_00_r    (rot_00),
    .rot_01_r    (rot_01),
    .rot_02_r    (rot_02),
    .rot_10_r    (rot_10),
    .rot_11_r    (rot_11),
    .rot_12_r    (rot_12),
    .rot_21_r    (rot_21),
    .rot_22_r    (rot_22),
    .trans_x_r   (trans_x),
    .trans_y_r   (trans_y),
    .trans_z_r   (trans_z)
  );

  assign res_data = OUT_DW'({trans_z, trans_y, trans_x, rot_22, rot_21, 1'b0,
                             rot_12, rot_11, rot_10, rot_02, rot_01, rot_00});
  assign push     = en && vld_r[VL-1];

  dhlt_skid #(
    .WIDTH (OUT_DW)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res_data),
    .can_push  (en),
    .m_tvalid  (out_tvalid),
    .m_tready  (out_tready),
    .m_tdata   (out_tdata)
  );

endmodule

[hdl/dhlt_cordic.sv]
// ----------------------------------------------------------------------------
// dhlt_cordic
// Pipelined rotation-mode cordic, one iteration per stage. Folds the angle
// into +-pi/2, iterates in q2.30 and rounds cos and sin to the coefficient
// format with saturation at +-1.0.
// ----------------------------------------------------------------------------
module dhlt_cordic import dhlt_pkg::*; #(
  parameter int ANGLE_WIDTH   = 16,
  parameter int COEFF_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic signed [COEFF_WIDTH-1:0] cos_o,
  output logic signed [COEFF_WIDTH-1:0] sin_o
);

  localparam int ZSH = INT_FRAC + 3 - ANGLE_WIDTH;
  localparam int RSH = INT_FRAC - (COEFF_WIDTH - 2);
  localparam logic [X_W:0] RHALF = (X_W+1)'((64'd1 << RSH) >> 1);
  localparam logic [X_W:0] RLIM  = (X_W+1)'(64'd1 << (COEFF_WIDTH - 2));

  logic signed [Z_IN_W-1:0] z_in;
  logic signed [Z_W-1:0]    z_fold;
  logic                     flip_in;

  logic signed [X_W-1:0] x_r    [CORDIC_STAGES+1];
  logic signed [X_W-1:0] y_r    [CORDIC_STAGES+1];
  logic signed [Z_W-1:0] z_r    [CORDIC_STAGES+1];
  logic                  flip_r [CORDIC_STAGES+1];

  function automatic logic signed [COEFF_WIDTH-1:0] to_coeff(
    input logic signed [X_W-1:0] v,
    input logic                  flip
  );
    logic           neg;
    logic [X_W-1:0] mag;
    logic [X_W:0]   rnd;
    logic [X_W:0]   lim_m;
    neg   = v[X_W-1] ^ flip;
    mag   = v[X_W-1] ? X_W'(-v) : X_W'(v);
    rnd   = (X_W+1)'(({1'b0, mag} + RHALF) >> RSH);
    lim_m = (rnd > RLIM) ? RLIM : rnd;
    return neg ? COEFF_WIDTH'(-lim_m) : COEFF_WIDTH'(lim_m);
  endfunction

  assign z_in = Z_IN_W'(angle) <<< ZSH;

  always_comb begin
    z_fold  = Z_W'(z_in);
    flip_in = 1'b0;
    if (z_in > HALF_PI_Q30) begin
      z_fold  = Z_W'(z_in - PI_Q30);
      flip_in = 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      z_fold  = Z_W'(z_in + PI_Q30);
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][Z_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - Z_W'(ATAN_Q30[i]);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + Z_W'(ATAN_Q30[i]);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= to_coeff(x_r[CORDIC_STAGES], flip_r[CORDIC_STAGES]);
      sin_o <= to_coeff(y_r[CORDIC_STAGES], flip_r[CORDIC_STAGES]);
    end
  end

endmodule

[hdl/dhlt_product.sv]
// ----------------------------------------------------------------------------
// dhlt_product
// Two-stage product unit: magnitude multiplies in the first stage, rounding
// to nearest (ties away from zero), sign and translation saturation in the
// second.
// ----------------------------------------------------------------------------
module dhlt_product import dhlt_pkg::*; #(
  parameter int COEFF_WIDTH  = 16,
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [COEFF_WIDTH-1:0]  cj,
  input  logic signed [COEFF_WIDTH-1:0]  sj,
  input  logic signed [COEFF_WIDTH-1:0]  ct,
  input  logic signed [COEFF_WIDTH-1:0]  st,
  input  logic signed [LENGTH_WIDTH-1:0] link_len,
  input  logic signed [LENGTH_WIDTH-1:0] link_offset,
  output logic signed [COEFF_WIDTH-1:0]  rot_00_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_01_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_02_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_10_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_11_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_12_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_21_r,
  output logic signed [COEFF_WIDTH-1:0]  rot_22_r,
  output logic signed [LENGTH_WIDTH-1:0] trans_x_r,
  output logic signed [LENGTH_WIDTH-1:0] trans_y_r,
  output logic signed [LENGTH_WIDTH-1:0] trans_z_r
);

  localparam int CF = COEFF_WIDTH - 2;
  localparam int PW = 2 * COEFF_WIDTH;
  localparam int TW = LENGTH_WIDTH + COEFF_WIDTH;
  localparam logic [PW:0] CHALF  = (PW+1)'(64'd1 << (CF - 1));
  localparam logic [TW:0] THALF  = (TW+1)'(64'd1 << (CF - 1));
  localparam logic [TW:0] TLIM_N = (TW+1)'(64'd1 << (LENGTH_WIDTH - 1));
  localparam logic [TW:0] TLIM_P = TLIM_N - (TW+1)'(1);

  logic [COEFF_WIDTH-1:0]  m_cj, m_sj, m_ct, m_st;
  logic [LENGTH_WIDTH-1:0] m_len;

  logic [PW-1:0] p01_r, p02_r, p11_r, p12_r;
  logic          n01_r, n02_r, n11_r, n12_r;
  logic [TW-1:0] px_r, py_r;
  logic          nx_r, ny_r;
  logic signed [COEFF_WIDTH-1:0]  cj_r, sj_r, ct_r, st_r;
  logic signed [LENGTH_WIDTH-1:0] off_r;

  function automatic logic [COEFF_WIDTH-1:0] mag_c(input logic signed [COEFF_WIDTH-1:0] v);
    return v[COEFF_WIDTH-1] ? COEFF_WIDTH'(-v) : COEFF_WIDTH'(v);
  endfunction

  function automatic logic signed [COEFF_WIDTH-1:0] round_c(
    input logic [PW-1:0] p,
    input logic          neg
  );
    logic [PW:0] rnd;
    rnd = (PW+1)'(({1'b0, p} + CHALF) >> CF);
    return neg ? COEFF_WIDTH'(-rnd) : COEFF_WIDTH'(rnd);
  endfunction

  function automatic logic signed [LENGTH_WIDTH-1:0] round_t(
    input logic [TW-1:0] p,
    input logic          neg
  );
    logic [TW:0] rnd;
    logic [TW:0] lim;
    logic [TW:0] m;
    rnd = (TW+1)'(({1'b0, p} + THALF) >> CF);
    lim = neg ? TLIM_N : TLIM_P;
    m   = (rnd > lim) ? lim : rnd;
    return neg ? LENGTH_WIDTH'(-m) : LENGTH_WIDTH'(m);
  endfunction

  assign m_cj  = mag_c(cj);
  assign m_sj  = mag_c(sj);
  assign m_ct  = mag_c(ct);
  assign m_st  = mag_c(st);
  assign m_len = link_len[LENGTH_WIDTH-1] ? LENGTH_WIDTH'(-link_len)
                                          : LENGTH_WIDTH'(link_len);

  always_ff @(posedge clk) begin
    if (en) begin
      p01_r <= PW'(m_sj) * PW'(m_ct);
      p02_r <= PW'(m_sj) * PW'(m_st);
      p11_r <= PW'(m_cj) * PW'(m_ct);
      p12_r <= PW'(m_cj) * PW'(m_st);
      // rot_01 and rot_12 carry a minus sign
      n01_r <= ~(sj[COEFF_WIDTH-1] ^ ct[COEFF_WIDTH-1]);
      n02_r <= sj[COEFF_WIDTH-1] ^ st[COEFF_WIDTH-1];
      n11_r <= cj[COEFF_WIDTH-1] ^ ct[COEFF_WIDTH-1];
      n12_r <= ~(cj[COEFF_WIDTH-1] ^ st[COEFF_WIDTH-1]);
      px_r  <= TW'(m_len) * TW'(m_cj);
      py_r  <= TW'(m_len) * TW'(m_sj);
      nx_r  <= link_len[LENGTH_WIDTH-1] ^ cj[COEFF_WIDTH-1];
      ny_r  <= link_len[LENGTH_WIDTH-1] ^ sj[COEFF_WIDTH-1];
      cj_r  <= cj;
      sj_r  <= sj;
      ct_r  <= ct;
      st_r  <= st;
      off_r <= link_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_00_r  <= cj_r;
      rot_01_r  <= round_c(p01_r, n01_r);
      rot_02_r  <= round_c(p02_r, n02_r);
      rot_10_r  <= sj_r;
      rot_11_r  <= round_c(p11_r, n11_r);
      rot_12_r  <= round_c(p12_r, n12_r);
      rot_21_r  <= st_r;
      rot_22_r  <= ct_r;
      trans_x_r <= round_t(px_r, nx_r);
      trans_y_r <= round_t(py_r, ny_r);
      trans_z_r <= off_r;
    end
  end

endmodule

[hdl/dhlt_skid.sv]
// ----------------------------------------------------------------------------
// dhlt_skid
// Output register with one skid entry. Holds back the pipeline only when
// both entries are full.
// ----------------------------------------------------------------------------
module dhlt_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             can_push,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [WIDTH-1:0] m_tdata
);

  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [WIDTH-1:0] out_d_r;
  logic [WIDTH-1:0] skid_d_r;
  logic             out_free;

  assign out_free = !out_v_r || m_tready;
  assign can_push = !skid_v_r;
  assign m_tvalid = out_v_r;
  assign m_tdata  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (m_tready) begin
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_v_nxt = 1'b1;
      end else begin
        skid_v_nxt = 1'b1;
      end
    end else if (m_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (m_tready) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (out_free) begin
        out_d_r <= push_data;
      end else begin
        skid_d_r <= push_data;
      end
    end
  end

endmodule

[hdl/dhlt_checker.sv]
// ----------------------------------------------------------------------------
// dhlt_checker
// Port-level checks on the link transform, bound to the top level.
// ----------------------------------------------------------------------------
module dhlt_checker import dhlt_pkg::*; #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int COEFF_WIDTH  = 16,
  parameter int LENGTH_WIDTH = 32,
  localparam int IN_DW  = byte_bits(2 * ANGLE_WIDTH + 2 * LENGTH_WIDTH),
  localparam int OUT_DW = byte_bits(8 * COEFF_WIDTH + 1 + 3 * LENGTH_WIDTH)
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_DW-1:0]  in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  localparam int RLIM = 1 << (COEFF_WIDTH - 2);

  logic signed [COEFF_WIDTH-1:0] rot_00;
  logic                          in_seen;

  assign rot_00  = out_tdata[COEFF_WIDTH-1:0];
  assign in_seen = in_tvalid || (in_tdata == in_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_seen && !in_tready |-> out_tvalid)
    else $error("input held off with no result waiting");

  a_rot20_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6*COEFF_WIDTH] == 1'b0)
    else $error("bottom left rotation entry not zero");

  a_rot00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rot_00 <= RLIM) && (rot_00 >= -RLIM))
    else $error("cos joint outside unit range");

endmodule

bind dh_link_transform dhlt_checker #(
  .ANGLE_WIDTH  (ANGLE_WIDTH),
  .COEFF_WIDTH  (COEFF_WIDTH),
  .LENGTH_WIDTH (LENGTH_WIDTH)
) u_dhlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[verif/dh_link_transform_checker.sv]
// ----------------------------------------------------------------------------
// dh_link_transform_checker
// Watches both stream channels of the link transform. Every accepted input
// beat is run through a bit-accurate cordic and fixed point model of the
// transform, and every result beat is compared field by field with the
// oldest predicted frame.
// ----------------------------------------------------------------------------
module dh_link_transform_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // joint_angle, twist_angle, link_len, link_offset
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // trans_x, trans_y, trans_z
  input  logic [231:0] out_tdata,
  output int           mismatches,
  output int           results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] link_offset;
    logic signed [31:0] link_len;
    logic signed [15:0] twist_angle;
    logic signed [15:0] joint_angle;
  } link_params_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] trans_z;
    logic [31:0] trans_y;
    logic [31:0] trans_x;
    logic [15:0] rot_22;
    logic [15:0] rot_21;
    logic        rot_20;
    logic [15:0] rot_12;
    logic [15:0] rot_11;
    logic [15:0] rot_10;
    logic [15:0] rot_02;
    logic [15:0] rot_01;
    logic [15:0] rot_00;
  } link_frame_t;

  localparam int      COEFF_FRAC   = 14;
  localparam int      Q30_TO_COEFF = 16;
  localparam int      ROTATIONS    = 16;
  localparam longint  UNIT_GAIN    = 64'sd652032874;
  localparam longint  ANGLE_PI     = 64'sd3373259426;
  localparam longint  ANGLE_HALF   = 64'sd1686629713;
  localparam longint unsigned COEFF_LIM = 64'd16384;
  localparam longint unsigned WIDE_LIM  = 64'd4611686018427387904;
  localparam longint unsigned POS_LIM   = 64'd2147483647;
  localparam longint unsigned NEG_LIM   = 64'd2147483648;

  localparam longint ARCTAN_STEP [16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767
  };

  link_frame_t frames_due [$];
  int          result_beats = 0;

  // round(a*b / 2^sh) half away from zero, magnitude clamped per sign
  function automatic longint scaled_round(input longint a, input longint b, input int sh,
                                          input longint unsigned lim_pos,
                                          input longint unsigned lim_neg);
    bit                neg;
    longint unsigned   mag;
    longint unsigned   lim;
    neg = (a < 0) != (b < 0);
    mag = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
    if (sh > 0)
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
    lim = neg ? lim_neg : lim_pos;
    if (mag > lim)
      mag = lim;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void trig_pair(input logic signed [15:0] angle,
                                    output longint cos_q, output longint sin_q);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    int     i;
    z    = longint'(angle) * 64'sd131072;
    x    = UNIT_GAIN;
    y    = 0;
    flip = 1'b0;
    if (z > ANGLE_HALF) begin
      z    = z - ANGLE_PI;
      flip = 1'b1;
    end else if (z < -ANGLE_HALF) begin
      z    = z + ANGLE_PI;
      flip = 1'b1;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_STEP[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q = scaled_round(x, 1, Q30_TO_COEFF, COEFF_LIM, COEFF_LIM);
    sin_q = scaled_round(y, 1, Q30_TO_COEFF, COEFF_LIM, COEFF_LIM);
  endfunction

  function automatic link_frame_t link_transform(input link_params_t p);
    link_frame_t f;
    longint      cj;
    longint      sj;
    longint      ct;
    longint      st;
    trig_pair(p.joint_angle, cj, sj);
    trig_pair(p.twist_angle, ct, st);
    f         = '0;
    f.rot_00  = 16'(cj);
    f.rot_01  = 16'(-scaled_round(sj, ct, COEFF_FRAC, WIDE_LIM, WIDE_LIM));
    f.rot_02  = 16'(scaled_round(sj, st, COEFF_FRAC, WIDE_LIM, WIDE_LIM));
    f.rot_10  = 16'(sj);
    f.rot_11  = 16'(scaled_round(cj, ct, COEFF_FRAC, WIDE_LIM, WIDE_LIM));
    f.rot_12  = 16'(-scaled_round(cj, st, COEFF_FRAC, WIDE_LIM, WIDE_LIM));
    f.rot_20  = 1'b0;
    f.rot_21  = 16'(st);
    f.rot_22  = 16'(ct);
    f.trans_x = 32'(scaled_round(p.link_len, cj, COEFF_FRAC, POS_LIM, NEG_LIM));
    f.trans_y = 32'(scaled_round(p.link_len, sj, COEFF_FRAC, POS_LIM, NEG_LIM));
    f.trans_z = p.link_offset;
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: result beat %0d: %s", $realtime, result_beats, what);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    link_frame_t got;
    link_frame_t want;
    if (!rst_n) begin
      frames_due.delete();
      results_due <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (frames_due.size() == 0) begin
          report_mismatch("beat with no transform pending");
        end else begin
          want = frames_due.pop_front();
          check_field("rot_00", got.rot_00, want.rot_00);
          check_field("rot_01", got.rot_01, want.rot_01);
          check_field("rot_02", got.rot_02, want.rot_02);
          check_field("rot_10", got.rot_10, want.rot_10);
          check_field("rot_11", got.rot_11, want.rot_11);
          check_field("rot_12", got.rot_12, want.rot_12);
          check_field("rot_20", got.rot_20, want.rot_20);
          check_field("rot_21", got.rot_21, want.rot_21);
          check_field("rot_22", got.rot_22, want.rot_22);
          check_field("trans_x", got.trans_x, want.trans_x);
          check_field("trans_y", got.trans_y, want.trans_y);
          check_field("trans_z", got.trans_z, want.trans_z);
          check_field("pad", got.pad, want.pad);
        end
        result_beats = result_beats + 1;
      end
      if (in_tvalid && in_tready)
        frames_due.insert(frames_due.size(), link_transform(link_params_t'(in_tdata)));
      results_due <= frames_due.size();
    end
  end

endmodule

[verif/dh_link_transform_test.sv]
// ----------------------------------------------------------------------------
// dh_link_transform_test
// Drives link parameters into the transform: a directed set of angle and
// length corners (fold boundaries, +-pi, full scale, saturating lengths),
// then random links in three phases, two with back-pressure. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dh_link_transform_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_LINKS   = 450;
  localparam int DRAIN_CYCLES   = 40;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [231:0] out_tdata;
  int           mismatches;
  int           results_due;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           quiet_cycles  = 0;

  always #4 clk = ~clk;

  dh_link_transform DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dh_link_transform_checker transform_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always @(negedge clk) begin
    if (rst_n)
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_link(input logic signed [15:0] joint, twist,
                           input logic signed [31:0] len, off);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {off, len, twist, joint};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // mostly full range, some near the pi/2 fold, +-pi and zero
  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] base;
    if ($urandom_range(3) != 0)
      return 16'($urandom);
    case ($urandom_range(4))
      0:       base = 16'sd12868;
      1:       base = -16'sd12868;
      2:       base = 16'sd25736;
      3:       base = -16'sd25736;
      default: base = 16'sd0;
    endcase
    return base + 16'($urandom_range(8)) - 16'sd4;
  endfunction

  function automatic logic signed [31:0] pick_length();
    if ($urandom_range(7) != 0)
      return 32'($urandom);
    case ($urandom_range(4))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  initial begin
    int phase;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_link(16'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_link(16'sd0, 16'sd0, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_link(16'sd0, 16'sd0, 32'sh8000_0000, 32'sh8000_0000);
    send_link(16'sd32767, -16'sd32768, 32'sh7fff_ffff, 32'sd0);
    send_link(-16'sd32768, 16'sd32767, 32'sh8000_0000, 32'sd1);
    send_link(16'sd12867, 16'sd12868, 32'sh0001_0000, -32'sd1);
    send_link(16'sd12868, -16'sd12867, 32'sh8000_0000, 32'sh0001_0000);
    send_link(-16'sd12868, -16'sd12868, 32'sh7fff_ffff, 32'sh1234_5678);
    send_link(-16'sd12867, 16'sd12867, 32'sh8000_0000, -32'sd65536);
    send_link(16'sd25736, -16'sd25736, 32'sh8000_0000, 32'sh7fff_ffff);
    send_link(-16'sd25736, 16'sd25736, 32'sh7fff_ffff, 32'sh8000_0000);
    send_link(16'sd1, -16'sd1, 32'sd1, -32'sd1);
    send_link(-16'sd1, 16'sd1, -32'sd1, 32'sd1);
    send_link(16'sd6434, -16'sd6434, 32'sh7fff_ffff, 32'sh0f0f_0f0f);
    send_link(16'sd19302, -16'sd19302, 32'sh8000_0000, 32'shf0f0_f0f0);
    send_link(16'sd12868, 16'sd0, 32'sh7fff_ffff, 32'sd0);
    send_link(-16'sd12868, 16'sd25736, 32'sh8000_0000, 32'sd0);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 32 : 0;
      repeat (RANDOM_LINKS / 3)
        send_link(pick_angle(), pick_angle(), pick_length(), pick_length());
    end
    in_tvalid <= 1'b0;

    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
